// ===== rtl/core/w5r_pkg.sv =====
// shared constants, types and elaboration helpers for the weno5 roe flux block
// no dependencies; imported by every other file of the block
package w5r_pkg;

  localparam int W5R_SAMPLE_WIDTH = 16;
  localparam int W5R_FRAC_BITS    = 12;
  localparam int W5R_VEL_WIDTH    = 16;
  localparam logic [W5R_VEL_WIDTH-1:0] W5R_VEL_RESET = 16'd4096;
  localparam int W5R_OUT_WIDTH    = 16;
  localparam int W5R_MAG_BITS     = 10;
  localparam int W5R_WT_BITS      = 16;
  // one quotient bit per stage, quotient never exceeds 2^WT_BITS
  localparam int W5R_DIV_STEPS    = W5R_WT_BITS + 1;
  // six front stages, divider stages, product and sum stages
  localparam int W5R_WENO_LAT     = W5R_DIV_STEPS + 8;
  localparam int W5R_ROE_LAT      = 3;

  typedef struct packed {
    logic signed [W5R_OUT_WIDTH-1:0] flux;
    logic                            sat;
  } w5r_flux_t;

  // epsilon in units of 12*beta, worked out at elaboration
  function automatic longint unsigned w5r_eps(input int sw, input int fb);
    int ds;
    int g2;
    longint unsigned e;
    ds = (sw > 16) ? sw - 16 : 0;
    g2 = 2 * (fb - ds);
    if (g2 < 0) begin
      return 64'd1;
    end
    e = ((64'd12 << g2) + 64'd500000) / 64'd1000000;
    return (e == 64'd0) ? 64'd1 : e;
  endfunction

endpackage

// ===== rtl/core/w5r_if.sv =====
// stream and configuration interfaces of the weno5 roe flux block
// depends on w5r_pkg
interface w5r_sample_if import w5r_pkg::*; #(parameter int SW = W5R_SAMPLE_WIDTH);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] sample_m2;
  logic signed [SW-1:0] sample_m1;
  logic signed [SW-1:0] sample_0;
  logic signed [SW-1:0] sample_p1;
  logic signed [SW-1:0] sample_p2;
  logic signed [SW-1:0] sample_p3;
  modport source (output valid, sample_m2, sample_m1, sample_0, sample_p1, sample_p2,
                  sample_p3, input ready);
  modport sink (input valid, sample_m2, sample_m1, sample_0, sample_p1, sample_p2,
                sample_p3, output ready);
endinterface

interface w5r_flux_if import w5r_pkg::*;;
  logic                            valid;
  logic                            ready;
  logic signed [W5R_OUT_WIDTH-1:0] interface_flux;
  logic                            saturated;
  modport source (output valid, interface_flux, saturated, input ready);
  modport sink (input valid, interface_flux, saturated, output ready);
endinterface

interface w5r_cfg_if import w5r_pkg::*;;
  logic                            valid;
  logic                            ready;
  logic signed [W5R_VEL_WIDTH-1:0] velocity;
  modport source (output valid, velocity, input ready);
  modport sink (input valid, velocity, output ready);
endinterface

// ===== rtl/core/weno5_roe_interface_flux_unit.sv =====
// weno5 roe interface flux, top level; one stencil per cycle while the output buffer is not full and held
// pipeline from sample beat to flux beat: 2 scaling stages, 25 weno stages
// (17 of them a one-bit-per-stage divider) and 3 roe stages
// a two-entry output buffer keeps accepting while a result waits
// synchronous reset empties the pipeline and buffer and sets velocity to 1.0
// depends on w5r_pkg, w5r_if, w5r_scale, w5r_weno, w5r_roe
module weno5_roe_interface_flux_unit import w5r_pkg::*; #(
  parameter int SAMPLE_WIDTH = W5R_SAMPLE_WIDTH,
  parameter int FRAC_BITS    = W5R_FRAC_BITS
) (
  input logic         clk,
  input logic         rst,
  w5r_cfg_if.sink     cfg,
  w5r_sample_if.sink  samples,
  w5r_flux_if.source  flux
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int RW = SW + 4;

  logic signed [W5R_VEL_WIDTH-1:0] velocity;
  logic                            en;

  // configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      velocity <= W5R_VEL_RESET;
    end else if (cfg.valid && cfg.ready) begin
      velocity <= cfg.velocity;
    end
  end

  assign samples.ready = en;

  logic signed [SW-1:0] u_in [6];
  assign u_in[0] = samples.sample_m2;
  assign u_in[1] = samples.sample_m1;
  assign u_in[2] = samples.sample_0;
  assign u_in[3] = samples.sample_p1;
  assign u_in[4] = samples.sample_p2;
  assign u_in[5] = samples.sample_p3;

  logic                 sc_valid;
  logic signed [SW-1:0] cu [6];
  logic signed [SW-1:0] us [6];
  logic                 sc_flag;

  w5r_scale #(.SW(SW), .FB(FRAC_BITS)) u_scale (
    .clk(clk), .rst(rst), .en(en), .in_valid(samples.valid),
    .u_in(u_in), .vel(velocity),
    .out_valid(sc_valid), .cu(cu), .u_out(us), .flag(sc_flag)
  );

  // left and mirrored right stencils
  logic signed [SW-1:0] fls [5];
  logic signed [SW-1:0] frs [5];
  logic signed [SW-1:0] uls [5];
  logic signed [SW-1:0] urs [5];
  always_comb begin
    for (int k = 0; k < 5; k++) begin
      fls[k] = cu[k];
      frs[k] = cu[5-k];
      uls[k] = us[k];
      urs[k] = us[5-k];
    end
  end

  logic                 wv [4];
  logic signed [RW-1:0] rec [4];

  w5r_weno #(.SW(SW), .FB(FRAC_BITS)) u_weno_fl (
    .clk(clk), .rst(rst), .en(en), .in_valid(sc_valid), .v(fls),
    .out_valid(wv[0]), .result(rec[0])
  );
  w5r_weno #(.SW(SW), .FB(FRAC_BITS)) u_weno_fr (
    .clk(clk), .rst(rst), .en(en), .in_valid(sc_valid), .v(frs),
    .out_valid(wv[1]), .result(rec[1])
  );
  w5r_weno #(.SW(SW), .FB(FRAC_BITS)) u_weno_ul (
    .clk(clk), .rst(rst), .en(en), .in_valid(sc_valid), .v(uls),
    .out_valid(wv[2]), .result(rec[2])
  );
  w5r_weno #(.SW(SW), .FB(FRAC_BITS)) u_weno_ur (
    .clk(clk), .rst(rst), .en(en), .in_valid(sc_valid), .v(urs),
    .out_valid(wv[3]), .result(rec[3])
  );

  w5r_flux_t beat;
  logic      all_valid;
  assign all_valid = wv[0] && wv[1] && wv[2] && wv[3];

  w5r_roe #(.SW(SW), .FB(FRAC_BITS)) u_roe (
    .clk(clk), .rst(rst), .flag_in(sc_flag), .in_valid(all_valid),
    .fl(rec[0]), .fr(rec[1]), .ul(rec[2]), .ur(rec[3]), .vel(velocity),
    .out_ready(flux.ready), .out_valid(flux.valid), .out_beat(beat), .en(en)
  );

  assign flux.interface_flux = beat.flux;
  assign flux.saturated      = beat.sat;

endmodule

// ===== rtl/core/w5r_scale.sv =====
// velocity scaling of the six samples, two stages: multiply, then round and clip
// depends on w5r_pkg
module w5r_scale import w5r_pkg::*; #(
  parameter int SW = W5R_SAMPLE_WIDTH,
  parameter int FB = W5R_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic signed [SW-1:0]            u_in [6],
  input  logic signed [W5R_VEL_WIDTH-1:0] vel,
  output logic                            out_valid,
  output logic signed [SW-1:0]            cu [6],
  output logic signed [SW-1:0]            u_out [6],
  output logic                            flag
);

  localparam int PRW = SW + W5R_VEL_WIDTH;
  localparam logic signed [PRW:0] HALF = (PRW + 1)'(1) <<< (FB - 1);
  localparam logic signed [PRW:0] HI   = ((PRW + 1)'(1) <<< (SW - 1)) - (PRW + 1)'(1);
  localparam logic signed [PRW:0] LO   = -((PRW + 1)'(1) <<< (SW - 1));

  logic signed [PRW-1:0] prod [6];
  logic signed [SW-1:0]  u1 [6];
  logic                  v1;
  logic signed [SW-1:0]  cu_next [6];
  logic                  flag_next;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        prod[k] <= vel * u_in[k];
        u1[k]   <= u_in[k];
      end
    end
  end

  // round half up, then clip to sample range
  always_comb begin
    logic signed [PRW:0] r;
    flag_next = 1'b0;
    for (int k = 0; k < 6; k++) begin
      r = ((PRW + 1)'(prod[k]) + HALF) >>> FB;
      if (r > HI) begin
        cu_next[k] = SW'(HI);
        flag_next  = 1'b1;
      end else if (r < LO) begin
        cu_next[k] = SW'(LO);
        flag_next  = 1'b1;
      end else begin
        cu_next[k] = SW'(r);
      end
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (en) begin
      cu    <= cu_next;
      u_out <= u1;
      flag  <= flag_next;
    end
  end

endmodule

// ===== rtl/core/w5r_weno.sv =====
// one fifth-order weno reconstruction, fully pipelined with a restoring divider
// depends on w5r_pkg
module w5r_weno import w5r_pkg::*; #(
  parameter int SW = W5R_SAMPLE_WIDTH,
  parameter int FB = W5R_FRAC_BITS,
  localparam int RW = SW + 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [SW-1:0] v [5],
  output logic                 out_valid,
  output logic signed [RW-1:0] result
);

  localparam int DS   = (SW > 16) ? SW - 16 : 0;
  localparam int DDW  = SW + 2;
  localparam int DSW  = SW + 3;
  localparam int EA   = DDW + 1 - DS;
  localparam int EB   = DSW + 1 - DS;
  localparam int PW   = SW + 6;
  localparam int BW   = 2 * EB + 5;
  localparam longint unsigned EPS = w5r_eps(SW, FB);
  localparam int EPSW = $clog2(EPS + 64'd1);
  localparam int DW   = ((EPSW > BW) ? EPSW : BW) + 1;
  localparam int BLW  = $clog2(DW + 1);
  localparam int MB   = W5R_MAG_BITS;
  localparam int SQW  = 2 * MB;
  localparam int ALW  = 2 * SQW + 4;
  localparam int SUMW = ALW + 2;
  localparam int WB   = W5R_WT_BITS;
  localparam int DIVN = W5R_DIV_STEPS;
  localparam int DVW  = SUMW + DIVN;
  localparam int WWW  = DIVN + 2;
  localparam int RSW  = PW + WWW + 2;
  localparam int LAT  = W5R_WENO_LAT;
  localparam int PDL  = DIVN + 5;
  localparam logic [DW-1:0]        EPSV  = DW'(EPS);
  localparam logic signed [WWW-1:0] ONE  = WWW'(1) <<< WB;
  localparam logic signed [RSW:0]   HALFR = (RSW + 1)'(1) <<< (WB + 2);

  logic [LAT-1:0] vl;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vl <= '0;
    end else if (en) begin
      vl <= {vl[LAT-2:0], in_valid};
    end
  end
  assign out_valid = vl[LAT-1];

  // stage 1: candidates and differences
  logic signed [DSW-1:0] x [5];
  logic signed [PW-1:0]  y [5];
  logic signed [DSW-1:0] dd [3];
  logic signed [DSW-1:0] dsv [3];
  logic signed [EA-1:0]  a_next [3];
  logic signed [EB-1:0]  b_next [3];
  logic signed [PW-1:0]  p_next [3];

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      x[k] = DSW'(v[k]);
      y[k] = PW'(v[k]);
    end
    dd[0]  = x[0] - (x[1] <<< 1) + x[2];
    dsv[0] = x[0] - (x[1] <<< 2) + (x[2] <<< 1) + x[2];
    dd[1]  = x[1] - (x[2] <<< 1) + x[3];
    dsv[1] = x[1] - x[3];
    dd[2]  = x[2] - (x[3] <<< 1) + x[4];
    dsv[2] = (x[2] <<< 1) + x[2] - (x[3] <<< 2) + x[4];
    p_next[0] = (y[0] <<< 1) + y[0] - (y[1] <<< 3) - (y[1] <<< 1) + (y[2] <<< 4) - y[2];
    p_next[1] = (y[2] <<< 2) + (y[2] <<< 1) + (y[3] <<< 1) + y[3] - y[1];
    p_next[2] = (y[2] <<< 1) + y[2] + (y[3] <<< 2) + (y[3] <<< 1) - y[4];
  end

  // difference pre-shift for wide samples
  if (DS == 0) begin : g_noshift
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        a_next[k] = EA'(dd[k]);
        b_next[k] = EB'(dsv[k]);
      end
    end
  end else begin : g_shift
    localparam logic signed [DSW:0] HD = (DSW + 1)'(1) <<< (DS - 1);
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        a_next[k] = EA'(((DSW + 1)'(dd[k]) + HD) >>> DS);
        b_next[k] = EB'(((DSW + 1)'(dsv[k]) + HD) >>> DS);
      end
    end
  end

  logic signed [EA-1:0] a1 [3];
  logic signed [EB-1:0] b1 [3];
  logic signed [PW-1:0] p1 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= a_next;
      b1 <= b_next;
      p1 <= p_next;
    end
  end

  // stage 2: smoothness plus epsilon, as 12*(eps+beta)
  logic signed [2*EA-1:0] sqa [3];
  logic signed [2*EB-1:0] sqb [3];
  logic [DW-1:0]          d_next [3];
  logic [DW-1:0]          d2 [3];

  always_comb begin
    logic [DW-1:0] la;
    logic [DW-1:0] lb;
    for (int k = 0; k < 3; k++) begin
      sqa[k] = a1[k] * a1[k];
      sqb[k] = b1[k] * b1[k];
      la = DW'(unsigned'(sqa[k]));
      lb = DW'(unsigned'(sqb[k]));
      d_next[k] = (la << 3) + (la << 2) + la + (lb << 1) + lb + EPSV;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2 <= d_next;
    end
  end

  // stage 3: common scale shift from the largest magnitude
  logic [DW-1:0]  mx;
  logic [BLW-1:0] bl;
  logic [BLW-1:0] t_next;
  logic [DW-1:0]  d3 [3];
  logic [BLW-1:0] t3;

  always_comb begin
    mx = d2[0];
    if (d2[1] > mx) mx = d2[1];
    if (d2[2] > mx) mx = d2[2];
    bl = '0;
    for (int j = 0; j < DW; j++) begin
      if (mx[j]) bl = BLW'(j + 1);
    end
    t_next = (bl > BLW'(MB)) ? bl - BLW'(MB) : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3 <= d2;
      t3 <= t_next;
    end
  end

  // stage 4: scaled magnitudes and squares
  logic [SQW-1:0] sq_next [3];
  logic [SQW-1:0] sq4 [3];

  always_comb begin
    logic [DW-1:0] nv;
    logic [MB-1:0] n;
    for (int k = 0; k < 3; k++) begin
      nv = d3[k] >> t3;
      n  = nv[MB-1:0];
      if (n == '0) n = MB'(1);
      sq_next[k] = n * n;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq4 <= sq_next;
    end
  end

  // stage 5: unnormalized weights
  logic [2*SQW-1:0] m12;
  logic [2*SQW-1:0] m02;
  logic [2*SQW-1:0] m01;
  logic [ALW-1:0]   al5 [3];

  assign m12 = sq4[1] * sq4[2];
  assign m02 = sq4[0] * sq4[2];
  assign m01 = sq4[0] * sq4[1];

  always_ff @(posedge clk) begin
    if (en) begin
      al5[0] <= ALW'(m12);
      al5[1] <= (ALW'(m02) << 3) + (ALW'(m02) << 1);
      al5[2] <= (ALW'(m01) << 2) + ALW'(m01);
    end
  end

  // stage 6: sum and rounded dividends
  logic [SUMW-1:0] s_sum;
  logic [DVW-1:0]  n0_6;
  logic [DVW-1:0]  n2_6;
  logic [DVW-1:0]  dv6;

  assign s_sum = SUMW'(al5[0]) + SUMW'(al5[1]) + SUMW'(al5[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      n0_6 <= (DVW'(al5[0]) << WB) + DVW'(s_sum >> 1);
      n2_6 <= (DVW'(al5[2]) << WB) + DVW'(s_sum >> 1);
      dv6  <= DVW'(s_sum);
    end
  end

  // restoring divider, one quotient bit per stage, msb first
  logic [DVW-1:0]  rm0 [DIVN];
  logic [DVW-1:0]  rm2 [DIVN];
  logic [DVW-1:0]  dvs [DIVN];
  logic [DIVN-1:0] q0 [DIVN];
  logic [DIVN-1:0] q2 [DIVN];

  for (genvar k = 0; k < DIVN; k++) begin : g_div
    logic [DVW-1:0]  r0_in;
    logic [DVW-1:0]  r2_in;
    logic [DVW-1:0]  dv_in;
    logic [DIVN-1:0] q0_in;
    logic [DIVN-1:0] q2_in;
    logic [DVW-1:0]  sh;
    logic            ge0;
    logic            ge2;
    if (k == 0) begin : g_first
      assign r0_in = n0_6;
      assign r2_in = n2_6;
      assign dv_in = dv6;
      assign q0_in = '0;
      assign q2_in = '0;
    end else begin : g_rest
      assign r0_in = rm0[k-1];
      assign r2_in = rm2[k-1];
      assign dv_in = dvs[k-1];
      assign q0_in = q0[k-1];
      assign q2_in = q2[k-1];
    end
    assign sh  = dv_in << (DIVN - 1 - k);
    assign ge0 = (r0_in >= sh);
    assign ge2 = (r2_in >= sh);
    always_ff @(posedge clk) begin
      if (en) begin
        rm0[k] <= ge0 ? r0_in - sh : r0_in;
        rm2[k] <= ge2 ? r2_in - sh : r2_in;
        dvs[k] <= dv_in;
        q0[k]  <= {q0_in[DIVN-2:0], ge0};
        q2[k]  <= {q2_in[DIVN-2:0], ge2};
      end
    end
  end

  // candidates wait for the weights
  logic signed [PW-1:0] pd [PDL][3];

  always_ff @(posedge clk) begin
    if (en) begin
      pd[0] <= p1;
      for (int k = 1; k < PDL; k++) begin
        pd[k] <= pd[k-1];
      end
    end
  end

  // weighted products, middle weight closes the sum to one
  logic signed [WWW-1:0]    w0;
  logic signed [WWW-1:0]    w1;
  logic signed [WWW-1:0]    w2;
  logic signed [PW+WWW-1:0] mp [3];

  assign w0 = signed'(WWW'(q0[DIVN-1]));
  assign w2 = signed'(WWW'(q2[DIVN-1]));
  assign w1 = ONE - w0 - w2;

  always_ff @(posedge clk) begin
    if (en) begin
      mp[0] <= w0 * pd[PDL-1][0];
      mp[1] <= w1 * pd[PDL-1][1];
      mp[2] <= w2 * pd[PDL-1][2];
    end
  end

  // sum and round to sample fraction
  logic signed [RSW:0] rsum;

  assign rsum = (RSW + 1)'(mp[0]) + (RSW + 1)'(mp[1]) + (RSW + 1)'(mp[2]) + HALFR;

  always_ff @(posedge clk) begin
    if (en) begin
      result <= RW'(rsum >>> (WB + 3));
    end
  end

endmodule

// ===== rtl/core/w5r_roe.sv =====
// roe combination of the four reconstructions, saturation, two-entry output buffer
// depends on w5r_pkg
module w5r_roe import w5r_pkg::*; #(
  parameter int SW = W5R_SAMPLE_WIDTH,
  parameter int FB = W5R_FRAC_BITS,
  localparam int RW = SW + 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            flag_in,
  input  logic                            in_valid,
  input  logic signed [RW-1:0]            fl,
  input  logic signed [RW-1:0]            fr,
  input  logic signed [RW-1:0]            ul,
  input  logic signed [RW-1:0]            ur,
  input  logic signed [W5R_VEL_WIDTH-1:0] vel,
  input  logic                            out_ready,
  output logic                            out_valid,
  output w5r_flux_t                       out_beat,
  output logic                            en
);

  localparam int SFW  = RW + 1;
  localparam int ACW  = W5R_VEL_WIDTH + 2;
  localparam int PRW  = ACW + SFW;
  localparam int NUMW = ((SFW + FB > PRW) ? SFW + FB : PRW) + 1;
  localparam int WL   = W5R_WENO_LAT;
  localparam int OW   = W5R_OUT_WIDTH;
  localparam logic signed [NUMW:0] HALF = (NUMW + 1)'(1) <<< FB;
  localparam logic signed [NUMW:0] HI   = ((NUMW + 1)'(1) <<< (OW - 1)) - (NUMW + 1)'(1);
  localparam logic signed [NUMW:0] LO   = -((NUMW + 1)'(1) <<< (OW - 1));

  logic [WL-1:0] fdl;
  logic [1:0]    vr;
  logic [1:0]    fr_flag;

  // stall only when both buffer entries hold and nothing drains
  logic [1:0] cnt;
  assign en = (cnt != 2'd2) || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= '0;
    end else if (en) begin
      vr <= {vr[0], in_valid};
    end
  end

  // scaling clip flag rides alongside the reconstructions
  always_ff @(posedge clk) begin
    if (en) begin
      fdl     <= {fdl[WL-2:0], flag_in};
      fr_flag <= {fr_flag[0], fdl[WL-1]};
    end
  end

  // speed magnitude
  logic signed [W5R_VEL_WIDTH:0] cx;
  logic signed [W5R_VEL_WIDTH:0] acm;
  logic signed [ACW-1:0]         acs;
  assign cx  = (W5R_VEL_WIDTH + 1)'(vel);
  assign acm = (cx < 0) ? -cx : cx;
  assign acs = signed'({1'b0, acm});

  // stage 1: flux sum and state jump
  logic signed [SFW-1:0] sumf1;
  logic signed [SFW-1:0] du1;
  always_ff @(posedge clk) begin
    if (en) begin
      sumf1 <= SFW'(fl) + SFW'(fr);
      du1   <= SFW'(ur) - SFW'(ul);
    end
  end

  // stage 2: upwind term
  logic signed [PRW-1:0]  prod2;
  logic signed [NUMW-1:0] shf2;
  always_ff @(posedge clk) begin
    if (en) begin
      prod2 <= acs * du1;
      shf2  <= NUMW'(sumf1) <<< FB;
    end
  end

  // stage 3: round by frac+1 and saturate
  logic signed [NUMW:0] rq;
  w5r_flux_t            res;
  always_comb begin
    rq = ((NUMW + 1)'(shf2) - (NUMW + 1)'(prod2) + HALF) >>> (FB + 1);
    res.sat = fr_flag[1];
    if (rq > HI) begin
      res.flux = OW'(HI);
      res.sat  = 1'b1;
    end else if (rq < LO) begin
      res.flux = OW'(LO);
      res.sat  = 1'b1;
    end else begin
      res.flux = OW'(rq);
    end
  end

  // output buffer
  w5r_flux_t buf_q [2];
  logic      wp;
  logic      rp;
  logic      push;
  logic      pop;

  assign push      = en && vr[1];
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt != 2'd0);
  assign out_beat  = buf_q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wp] <= res;
    end
  end

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for weno5_roe_interface_flux_unit
// depends on w5r_pkg, w5r_if and weno5_roe_interface_flux_unit from the rtl; predicts each flux beat with its own model
`timescale 1ns / 100ps

module testbench;
  import w5r_pkg::*;

  localparam int PIPE_DRAIN = 40;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1350;

  typedef logic signed [W5R_SAMPLE_WIDTH-1:0] samp_t;

  typedef struct {
    samp_t s[6];
    bit    known;
    samp_t flux;
    bit    sat;
  } stim_row_t;

  logic clk;
  logic rst;

  w5r_cfg_if    cfg_bus();
  w5r_sample_if samp_bus();
  w5r_flux_if   flux_bus();

  weno5_roe_interface_flux_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_bus),
    .samples(samp_bus),
    .flux(flux_bus)
  );

  // model copy of the velocity register
  logic signed [W5R_VEL_WIDTH-1:0] model_velocity;
  w5r_flux_t pending_flux[$];
  int mismatches;
  int flux_beats;
  int stencils_sent;
  int hold_cycles;
  bit no_idle;
  bit stall_request;
  int idle_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // rounded arithmetic right shift, half toward plus infinity
  function automatic longint round_shr(longint x, int n);
    if (n == 0) begin
      return x;
    end
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi, ref bit flag);
    if (x < lo) begin
      flag = 1'b1;
      return lo;
    end
    if (x > hi) begin
      flag = 1'b1;
      return hi;
    end
    return x;
  endfunction

  // 12*beta from a second difference and a first difference
  function automatic longint unsigned beta12(longint dd, longint ds);
    int dsh;
    longint a;
    longint b;
    dsh = (W5R_SAMPLE_WIDTH > 16) ? W5R_SAMPLE_WIDTH - 16 : 0;
    a = round_shr(dd, dsh);
    b = round_shr(ds, dsh);
    return 13 * longint'(a * a) + 3 * longint'(b * b);
  endfunction

  // fifth-order reconstruction at the right face of the middle cell
  function automatic longint weno_face(longint v[5]);
    longint p[3];
    longint unsigned d[3];
    longint unsigned q[3];
    longint unsigned al[3];
    longint unsigned eps;
    longint unsigned mx;
    longint unsigned tot;
    longint unsigned w0;
    longint unsigned w1;
    longint unsigned w2;
    int bl;
    int sh;
    longint acc;
    eps = w5r_eps(W5R_SAMPLE_WIDTH, W5R_FRAC_BITS);
    p[0] = 3 * v[0] - 10 * v[1] + 15 * v[2];
    p[1] = -v[1] + 6 * v[2] + 3 * v[3];
    p[2] = 3 * v[2] + 6 * v[3] - v[4];
    d[0] = eps + beta12(v[0] - 2 * v[1] + v[2], v[0] - 4 * v[1] + 3 * v[2]);
    d[1] = eps + beta12(v[1] - 2 * v[2] + v[3], v[1] - v[3]);
    d[2] = eps + beta12(v[2] - 2 * v[3] + v[4], 3 * v[2] - 4 * v[3] + v[4]);
    mx = d[0];
    if (d[1] > mx) mx = d[1];
    if (d[2] > mx) mx = d[2];
    bl = 0;
    while (bl < 64 && (mx >> bl) != 0) bl++;
    sh = (bl > W5R_MAG_BITS) ? bl - W5R_MAG_BITS : 0;
    for (int k = 0; k < 3; k++) begin
      q[k] = d[k] >> sh;
      if (q[k] == 0) q[k] = 1;
      q[k] = q[k] * q[k];
    end
    al[0] = q[1] * q[2];
    al[1] = 10 * q[0] * q[2];
    al[2] = 5 * q[0] * q[1];
    tot = al[0] + al[1] + al[2];
    w0 = ((al[0] << W5R_WT_BITS) + tot / 2) / tot;
    w2 = ((al[2] << W5R_WT_BITS) + tot / 2) / tot;
    w1 = (64'd1 << W5R_WT_BITS) - w0 - w2;
    acc = longint'(w0) * p[0] + longint'(w1) * p[1] + longint'(w2) * p[2];
    return round_shr(acc, W5R_WT_BITS + 3);
  endfunction

  // roe flux at the interface for one stencil
  function automatic w5r_flux_t roe_flux(samp_t s[6]);
    longint c;
    longint ac;
    longint u[6];
    longint cu[6];
    longint lf[5];
    longint rf[5];
    longint ls[5];
    longint rs[5];
    longint num;
    longint lo;
    longint hi;
    bit flag;
    w5r_flux_t r;
    flag = 1'b0;
    c = longint'(model_velocity);
    ac = (c < 0) ? -c : c;
    lo = -(64'sd1 <<< (W5R_SAMPLE_WIDTH - 1));
    hi = (64'sd1 <<< (W5R_SAMPLE_WIDTH - 1)) - 1;
    for (int k = 0; k < 6; k++) begin
      u[k] = longint'(s[k]);
      cu[k] = clamp(round_shr(c * u[k], W5R_FRAC_BITS), lo, hi, flag);
    end
    for (int k = 0; k < 5; k++) begin
      lf[k] = cu[k];
      rf[k] = cu[5 - k];
      ls[k] = u[k];
      rs[k] = u[5 - k];
    end
    num = (weno_face(lf) + weno_face(rf)) * (64'sd1 <<< W5R_FRAC_BITS)
          - ac * (weno_face(rs) - weno_face(ls));
    r.flux = samp_t'(clamp(round_shr(num, W5R_FRAC_BITS + 1), -32768, 32767, flag));
    r.sat = flag;
    return r;
  endfunction

  // one stencil beat, with random idle cycles before it
  task automatic send_stencil(samp_t s[6], bit known, samp_t ef, bit es);
    w5r_flux_t e;
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 18) begin
      samp_bus.valid = 1'b0;
      @(negedge clk);
    end
    samp_bus.valid = 1'b1;
    samp_bus.sample_m2 = s[0];
    samp_bus.sample_m1 = s[1];
    samp_bus.sample_0 = s[2];
    samp_bus.sample_p1 = s[3];
    samp_bus.sample_p2 = s[4];
    samp_bus.sample_p3 = s[5];
    do @(posedge clk); while (!samp_bus.ready);
    e = roe_flux(s);
    if (known && (e.flux !== ef || e.sat !== es)) begin
      $display("table row disagrees with predictor: %0d/%0d vs %0d/%0d",
               ef, es, e.flux, e.sat);
    end
    if (known) begin
      e.flux = ef;
      e.sat = es;
    end
    pending_flux.push_back(e);
    stencils_sent++;
    if (stencils_sent == 300) stall_request = 1'b1;
  endtask

  task automatic end_of_stream();
    @(negedge clk);
    samp_bus.valid = 1'b0;
  endtask

  // velocity write once the pipeline has drained
  task automatic write_velocity(logic signed [W5R_VEL_WIDTH-1:0] v);
    end_of_stream();
    while (pending_flux.size() > 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.velocity = v;
    do @(posedge clk); while (!cfg_bus.ready);
    model_velocity = v;
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // random stencil: smooth ramps with noise, flat rows, rough data, extremes
  function automatic void make_stencil(output samp_t s[6]);
    int kind;
    int base;
    int slope;
    kind = $urandom_range(9);
    base = int'($urandom_range(65535)) - 32768;
    slope = int'($urandom_range(2000)) - 1000;
    for (int k = 0; k < 6; k++) begin
      case (kind)
        0, 1, 2: s[k] = samp_t'($urandom);
        3: s[k] = $urandom_range(1) ? samp_t'(16'h8000) : samp_t'(16'h7fff);
        4, 5: s[k] = samp_t'(int'($urandom_range(8191)) - 4096);
        6: s[k] = samp_t'(base);
        default: s[k] = samp_t'((base / 2) + slope * k + int'($urandom_range(64)) - 32);
      endcase
    end
    // occasional discontinuity inside a smooth stencil
    if (kind >= 7 && $urandom_range(3) == 0) s[$urandom_range(5)] = samp_t'($urandom);
  endfunction

  // flux receiver: random back-pressure plus one long hold
  initial begin
    flux_bus.ready = 1'b0;
    mismatches = 0;
    flux_beats = 0;
    hold_cycles = 0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        hold_cycles = 300;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        flux_bus.ready = 1'b0;
      end else begin
        flux_bus.ready = rst ? 1'b0 : (no_idle || $urandom_range(99) >= 18);
      end
      @(posedge clk);
      if (flux_bus.valid && flux_bus.ready) begin
        flux_beats++;
        if (pending_flux.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("flux beat with nothing pending: %0d",
                                         flux_bus.interface_flux);
        end else begin
          w5r_flux_t e;
          e = pending_flux.pop_front();
          if (flux_bus.interface_flux !== e.flux || flux_bus.saturated !== e.sat) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("flux mismatch beat %0d: expected %0d sat %0d, got %0d sat %0d",
                       flux_beats, e.flux, e.sat, flux_bus.interface_flux,
                       flux_bus.saturated);
            end
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  initial begin
    idle_count = 0;
    forever begin
      @(posedge clk);
      if ((samp_bus.valid && samp_bus.ready) || (flux_bus.valid && flux_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        idle_count = 0;
      end else begin
        idle_count++;
      end
      if (idle_count >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("weno5_roe_interface_flux_unit regression: fail");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t dir_rows[$];
    stim_row_t row;
    samp_t s[6];
    logic signed [W5R_VEL_WIDTH-1:0] vel_plan[7];
    int wait_cycles;

    rst = 1'b1;
    no_idle = 1'b0;
    stall_request = 1'b0;
    stencils_sent = 0;
    model_velocity = W5R_VEL_RESET;
    samp_bus.valid = 1'b0;
    samp_bus.sample_m2 = '0;
    samp_bus.sample_m1 = '0;
    samp_bus.sample_0 = '0;
    samp_bus.sample_p1 = '0;
    samp_bus.sample_p2 = '0;
    samp_bus.sample_p3 = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.velocity = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed stencils at reset velocity; flat rows reconstruct exactly
    row.known = 1'b1;
    row.s = '{0, 0, 0, 0, 0, 0};        row.flux = 0;      row.sat = 0; dir_rows.push_back(row);
    row.s = '{1000, 1000, 1000, 1000, 1000, 1000};
                                        row.flux = 1000;   row.sat = 0; dir_rows.push_back(row);
    row.s = '{32767, 32767, 32767, 32767, 32767, 32767};
                                        row.flux = 32767;  row.sat = 0; dir_rows.push_back(row);
    row.s = '{-32768, -32768, -32768, -32768, -32768, -32768};
                                        row.flux = -32768; row.sat = 0; dir_rows.push_back(row);
    row.s = '{-1, -1, -1, -1, -1, -1};  row.flux = -1;     row.sat = 0; dir_rows.push_back(row);
    row.known = 1'b0;
    row.s = '{-32768, 32767, -32768, 32767, -32768, 32767}; dir_rows.push_back(row);
    row.s = '{32767, -32768, 32767, -32768, 32767, -32768}; dir_rows.push_back(row);
    row.s = '{-32768, -32768, -32768, 32767, 32767, 32767}; dir_rows.push_back(row);
    row.s = '{32767, 32767, 32767, -32768, -32768, -32768}; dir_rows.push_back(row);
    row.s = '{0, 0, 32767, 0, 0, 0};      dir_rows.push_back(row);
    row.s = '{0, 0, 0, -32768, 0, 0};     dir_rows.push_back(row);
    row.s = '{0, 4096, 8192, 12288, 16384, 20480}; dir_rows.push_back(row);
    row.s = '{20480, 16384, 12288, 8192, 4096, 0}; dir_rows.push_back(row);
    row.s = '{1, 0, 1, 0, 1, 0};          dir_rows.push_back(row);
    row.s = '{-4096, -1024, 0, 1024, 4096, 9216}; dir_rows.push_back(row);
    foreach (dir_rows[i]) send_stencil(dir_rows[i].s, dir_rows[i].known,
                                       dir_rows[i].flux, dir_rows[i].sat);

    // velocity phases, extremes included; clipping shows up at large speeds
    vel_plan = '{16'sh7fff, -16'sh8000, 16'sh0000, -16'sh1000,
                 samp_t'($urandom), 16'sh1000, samp_t'($urandom)};
    for (int ph = 0; ph < 7; ph++) begin
      write_velocity(vel_plan[ph]);
      if (ph == 2) begin
        s = '{32767, 32767, 32767, 32767, 32767, 32767};
        send_stencil(s, 1'b1, 0, 0);
      end
      for (int n = 0; n < RANDOM_ITEMS / 7; n++) begin
        no_idle = (ph == 5 && n < 120);
        make_stencil(s);
        send_stencil(s, 1'b0, 0, 0);
      end
      no_idle = 1'b0;
    end
    end_of_stream();

    // drain
    wait_cycles = 0;
    while (pending_flux.size() > 0 && wait_cycles < STALL_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (PIPE_DRAIN) @(posedge clk);

    $display("covered %0d stencils over 8 velocity settings incl. both extremes and zero,",
             stencils_sent);
    $display("%0d flux beats checked, %0d mismatches, %0d left pending",
             flux_beats, mismatches, pending_flux.size());
    if (mismatches == 0 && pending_flux.size() == 0) begin
      $display("weno5_roe_interface_flux_unit regression: pass");
    end else begin
      $display("weno5_roe_interface_flux_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/w5r_pkg.sv
rtl/core/w5r_if.sv
rtl/core/w5r_scale.sv
rtl/core/w5r_weno.sv
rtl/core/w5r_roe.sv
rtl/core/weno5_roe_interface_flux_unit.sv
bench/testbench.sv
